// ----- rtl/quaternion_to_euler_angles_top_assert.svh -----
// assertion macros for the quaternion to euler block
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
// property a implies b on the next clock
`define Q2E_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("q2e check failed");
// property a implies b on the same clock
`define Q2E_ASSERT_SAME(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("q2e check failed");
`endif

// ----- rtl/q2e_pkg.sv -----
package q2e_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int CSW = 64;
    // square root: two result bits per stage over a 64-bit radicand
    localparam int SQRT_STAGES = 16;
    localparam int SQRT_LAT = SQRT_STAGES + 1;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_NOQ = 2'd2;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic               read_failed;
        logic               quat_present;
    } t_in;

    typedef struct packed {
        logic signed [14:0] pitch_centideg;
        logic signed [15:0] roll_centideg;
        logic signed [15:0] yaw_centideg;
        logic [1:0]         status;
    } t_out;

    // one cordic lane: vector and angle
    typedef struct packed {
        logic signed [CSW-1:0] x;
        logic signed [CSW-1:0] y;
        logic signed [CSW-1:0] z;
    } t_vec;

    function automatic logic signed [CSW-1:0] atan_tab(input logic [4:0] i);
        logic signed [CSW-1:0] r;
        case (i)
            5'd0: r = 64'h3243F6A8;  5'd1: r = 64'h1DAC6705;
            5'd2: r = 64'h0FADBAFC;  5'd3: r = 64'h07F56EA6;
            5'd4: r = 64'h03FEAB76;  5'd5: r = 64'h01FFD55B;
            5'd6: r = 64'h00FFFAAA;  5'd7: r = 64'h007FFF55;
            5'd8: r = 64'h003FFFEA;  5'd9: r = 64'h001FFFFD;
            5'd10: r = 64'h000FFFFF; 5'd11: r = 64'h0007FFFF;
            5'd12: r = 64'h0003FFFF; 5'd13: r = 64'h0001FFFF;
            5'd14: r = 64'h0000FFFF; 5'd15: r = 64'h00007FFF;
            5'd16: r = 64'h00003FFF; 5'd17: r = 64'h00001FFF;
            5'd18: r = 64'h00000FFF; 5'd19: r = 64'h000007FF;
            5'd20: r = 64'h000003FF; 5'd21: r = 64'h000001FF;
            5'd22: r = 64'h000000FF; 5'd23: r = 64'h0000007F;
            5'd24: r = 64'h0000003F; 5'd25: r = 64'h0000001F;
            5'd26: r = 64'h0000000F; 5'd27: r = 64'h00000007;
            5'd28: r = 64'h00000003; 5'd29: r = 64'h00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

    // quadrant pre-rotation of a vector before the cordic
    function automatic t_vec pre_rot(input logic signed [CSW-1:0] y,
                                     input logic signed [CSW-1:0] x);
        t_vec v;
        v.x = x; v.y = y; v.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y; v.y = -x; v.z = HALF_PI_Q30;
            end else begin
                v.x = -y; v.y = x; v.z = -HALF_PI_Q30;
            end
        end
        return v;
    endfunction

    // one cordic micro-rotation
    function automatic t_vec cstep(input t_vec v, input logic [4:0] i);
        t_vec o;
        logic signed [CSW-1:0] xs, ys;
        xs = v.x >>> i;
        ys = v.y >>> i;
        o = v;
        if (v.y > 0) begin
            o.x = v.x + ys; o.y = v.y - xs; o.z = v.z + atan_tab(i);
        end else if (v.y < 0) begin
            o.x = v.x - ys; o.y = v.y + xs; o.z = v.z - atan_tab(i);
        end
        return o;
    endfunction
endpackage

// ----- rtl/q2e_front.sv -----
// products and sums feeding the three angle paths, two register stages
module q2e_front import q2e_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_in                   i_d,
    output logic signed [CSW-1:0] o_s,
    output logic signed [CSW-1:0] o_ry,
    output logic signed [CSW-1:0] o_rx,
    output logic signed [CSW-1:0] o_yy,
    output logic signed [CSW-1:0] o_yx
);
    logic signed [CSW-1:0] r_wy, r_xz, r_yz, r_wx, r_xx, r_yy, r_xy, r_wz, r_zz;
    logic signed [CSW-1:0] n_s;

    // stage a: nine q30 products, floored
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wy <= (CSW'(i_d.quat_w) * CSW'(i_d.quat_y)) >>> 30;
            r_xz <= (CSW'(i_d.quat_x) * CSW'(i_d.quat_z)) >>> 30;
            r_yz <= (CSW'(i_d.quat_y) * CSW'(i_d.quat_z)) >>> 30;
            r_wx <= (CSW'(i_d.quat_w) * CSW'(i_d.quat_x)) >>> 30;
            r_xx <= (CSW'(i_d.quat_x) * CSW'(i_d.quat_x)) >>> 30;
            r_yy <= (CSW'(i_d.quat_y) * CSW'(i_d.quat_y)) >>> 30;
            r_xy <= (CSW'(i_d.quat_x) * CSW'(i_d.quat_y)) >>> 30;
            r_wz <= (CSW'(i_d.quat_w) * CSW'(i_d.quat_z)) >>> 30;
            r_zz <= (CSW'(i_d.quat_z) * CSW'(i_d.quat_z)) >>> 30;
        end
    end

    // saturated asin argument
    always_comb begin
        n_s = (r_wy - r_xz) <<< 1;
        if (n_s > ONE_Q30) n_s = ONE_Q30;
        if (n_s < -ONE_Q30) n_s = -ONE_Q30;
    end

    // stage b: sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s  <= n_s;
            o_ry <= (r_yz + r_wx) <<< 1;
            o_rx <= ONE_Q30 - ((r_xx + r_yy) <<< 1);
            o_yy <= (r_xy + r_wz) <<< 1;
            o_yx <= ONE_Q30 - ((r_yy + r_zz) <<< 1);
        end
    end
endmodule

// ----- rtl/q2e_sqrt.sv -----
// pipelined integer square root of 2^60 - s*s, two result bits per stage
module q2e_sqrt import q2e_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [CSW-1:0] i_s,
    output logic signed [CSW-1:0] o_c
);
    localparam int NST = SQRT_STAGES;
    logic [63:0] r_v [NST+1];
    logic [63:0] r_res [NST+1];
    logic [63:0] r_sq;
    logic [63:0] n_v [NST];
    logic [63:0] n_res [NST];
    logic signed [31:0] s32;

    // saturated argument fits in 32 bits
    assign s32 = i_s[31:0];

    // square of the argument, registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= 64'(s32 * s32);
        end
    end

    always_comb begin
        r_v[0] = (64'd1 << 60) - r_sq;
        r_res[0] = '0;
    end

    // restoring root, two pairs of bits per stage (bit 2^62 down)
    for (genvar g = 0; g < NST; g++) begin : g_st
        always_comb begin
            logic [63:0] v, res, b;
            v = r_v[g];
            res = r_res[g];
            for (int k = 0; k < 2; k++) begin
                b = 64'd1 << (62 - 2 * (2 * g + k));
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
            end
            n_v[g] = v;
            n_res[g] = res;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g+1] <= n_v[g];
                r_res[g+1] <= n_res[g];
            end
        end
    end

    assign o_c = $signed(r_res[NST]);
endmodule

// ----- rtl/q2e_cordic.sv -----
// vectoring cordic, one register stage per iteration, then scaling
module q2e_cordic import q2e_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [CSW-1:0] i_y,
    input  logic signed [CSW-1:0] i_x,
    output logic signed [15:0]    o_cd
);
    t_vec r_v [CORDIC_STAGES+1];
    logic signed [CSW-1:0] r_prod;
    logic                  r_neg;
    logic signed [CSW-1:0] mag, cd;

    // quadrant fold
    always_ff @(posedge i_clk) begin
        if (i_en) r_v[0] <= pre_rot(i_y, i_x);
    end

    // micro-rotations
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en) r_v[g+1] <= cstep(r_v[g], 5'(g));
        end
    end

    // scale to centidegrees
    assign mag = r_v[CORDIC_STAGES].z < 0 ? -r_v[CORDIC_STAGES].z : r_v[CORDIC_STAGES].z;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= mag * 64'sd5730 + (64'sd1 <<< 29);
            r_neg  <= r_v[CORDIC_STAGES].z < 0;
        end
    end
    assign cd = r_prod >>> 30;
    assign o_cd = r_neg ? 16'(-cd) : 16'(cd);
endmodule

// ----- rtl/quaternion_to_euler_angles_top.sv -----
// accept to output: front, root square and stages, cordic fold, rotations, scaling;
// pitch path sets depth, roll and yaw are delay matched
// throughput: one item per cycle, whole pipeline halts while output is stalled
// reset clears the valid bits only; datapath registers are not reset
module quaternion_to_euler_angles_top import q2e_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    localparam int SQD = SQRT_LAT;
    localparam int LAT = 2 + SQD + CORDIC_STAGES + 2;

    logic en;
    logic [LAT-1:0] r_vld;
    logic [1:0] r_st [LAT];
    logic signed [CSW-1:0] s, ry, rx, yy, yx, c;
    logic signed [CSW-1:0] r_ry [SQD], r_rx [SQD], r_yy [SQD], r_yx [SQD], r_sd [SQD];
    logic signed [15:0] pcd, rcd, ycd;

    // pipeline advances when output not stalled
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // status travels with the item
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= i_data.read_failed ? ST_FAIL :
                       (!i_data.quat_present ? ST_NOQ : ST_OK);
            for (int k = 1; k < LAT; k++) r_st[k] <= r_st[k-1];
        end
    end

    q2e_front u_front (.i_clk, .i_en(en), .i_d(i_data), .o_s(s), .o_ry(ry),
                       .o_rx(rx), .o_yy(yy), .o_yx(yx));
    q2e_sqrt u_sqrt (.i_clk, .i_en(en), .i_s(s), .o_c(c));

    // delay match roll, yaw and s to the root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ry[0] <= ry; r_rx[0] <= rx; r_yy[0] <= yy; r_yx[0] <= yx; r_sd[0] <= s;
            for (int k = 1; k < SQD; k++) begin
                r_ry[k] <= r_ry[k-1]; r_rx[k] <= r_rx[k-1];
                r_yy[k] <= r_yy[k-1]; r_yx[k] <= r_yx[k-1]; r_sd[k] <= r_sd[k-1];
            end
        end
    end

    q2e_cordic u_pitch (.i_clk, .i_en(en), .i_y(r_sd[SQD-1]), .i_x(c), .o_cd(pcd));
    q2e_cordic u_roll (.i_clk, .i_en(en), .i_y(r_ry[SQD-1]), .i_x(r_rx[SQD-1]),
                       .o_cd(rcd));
    q2e_cordic u_yaw (.i_clk, .i_en(en), .i_y(r_yy[SQD-1]), .i_x(r_yx[SQD-1]),
                      .o_cd(ycd));

    // output with error zeroing
    assign o_valid = r_vld[LAT-1];
    always_comb begin
        o_data.status = r_st[LAT-1];
        o_data.pitch_centideg = (r_st[LAT-1] == ST_OK) ? pcd[14:0] : '0;
        o_data.roll_centideg  = (r_st[LAT-1] == ST_OK) ? rcd : '0;
        o_data.yaw_centideg   = (r_st[LAT-1] == ST_OK) ? ycd : '0;
    end
endmodule

// ----- rtl/q2e_checker.sv -----
`include "quaternion_to_euler_angles_top_assert.svh"
// port-level checks of the converter
module q2e_checker import q2e_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);
    `Q2E_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `Q2E_ASSERT_SAME(a_stat, i_clk, i_rst_n, o_valid, o_data.status != 2'd3)
    `Q2E_ASSERT_SAME(a_zero, i_clk, i_rst_n, o_valid && o_data.status != ST_OK,
        o_data.pitch_centideg == 0 && o_data.roll_centideg == 0)
    `Q2E_ASSERT_SAME(a_stall, i_clk, i_rst_n, o_stall, o_valid && i_stall)
endmodule

bind quaternion_to_euler_angles_top q2e_checker u_chk (.i_clk, .i_rst_n,
    .o_stall, .o_valid, .i_stall, .o_data);
